FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the speed pulse block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked on every rising edge outside reset
`define ASSERT_IMPLIES(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

`endif

FILE: rtl/spfo_pkg.sv
// ----------------------------------------------------------------------------
// spfo_pkg
// types and constants shared by the speed pulse frequency output block
// ----------------------------------------------------------------------------
package spfo_pkg;

  localparam int OP_W    = 2;
  localparam int SPEED_W = 8;
  localparam int TIME_W  = 32;
  localparam int MODE_W  = 4;
  localparam int FREQ_W  = 11;
  localparam int HP_W    = 9;
  localparam int SM_W    = SPEED_W + MODE_W;
  localparam int NUM_W   = 22;
  localparam int DEN_W   = 11;
  localparam int CNT_W   = $clog2(NUM_W);
  localparam int RECIP_W = 23;
  localparam int RECIP_SHIFT = 23;
  localparam int PROD_W  = SM_W + RECIP_W;

  localparam logic [OP_W-1:0] OP_SET  = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK = 2'd1;
  localparam logic [OP_W-1:0] OP_STOP = 2'd2;

  localparam logic [NUM_W-1:0]  SPEED_SCALE        = 22'd1000;
  localparam logic [DEN_W-1:0]  KMH_PER_MILE_X1000 = 11'd1609;
  localparam logic [NUM_W-1:0]  HALF_PERIOD_NUM    = 22'd500;
  localparam logic [FREQ_W-1:0] FREQ_MIN_HZ        = 11'd1;
  localparam logic [FREQ_W-1:0] FREQ_MAX_HZ        = 11'd2000;
  localparam logic [HP_W-1:0]   HP_MIN             = 9'd1;
  localparam logic [MODE_W-1:0] MODE_RESET         = 4'd1;
  // 1000/1609 scaled by 2^23, rounded up, exact for every speed times mode
  localparam logic [RECIP_W-1:0] FREQ_RECIP        = 23'd5213554;

  typedef enum logic [2:0] {
    K_SET,
    K_ZERO,
    K_TICK,
    K_STOP,
    K_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [SPEED_W-1:0] speed;
    logic [TIME_W-1:0]  time_ms;
  } cmd_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quo;
  } div_rsp_t;

endpackage

FILE: rtl/spfo_front.sv
// ----------------------------------------------------------------------------
// spfo_front
// accepts input items, classifies them and pushes commands into the queue
// ----------------------------------------------------------------------------
module spfo_front (
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [spfo_pkg::OP_W-1:0]     in_op,
  input  logic [spfo_pkg::SPEED_W-1:0]  in_speed_kmh,
  input  logic [spfo_pkg::TIME_W-1:0]   in_time_ms,
  input  logic                          q_full,
  output logic                          q_push,
  output spfo_pkg::cmd_t                q_cmd
);

  spfo_pkg::cmd_kind_t kind;

  always_comb begin
    case (in_op)
      spfo_pkg::OP_SET: begin
        kind = (in_speed_kmh == '0) ? spfo_pkg::K_ZERO : spfo_pkg::K_SET;
      end
      spfo_pkg::OP_TICK: begin
        kind = spfo_pkg::K_TICK;
      end
      spfo_pkg::OP_STOP: begin
        kind = spfo_pkg::K_STOP;
      end
      default: begin
        kind = spfo_pkg::K_NOP;
      end
    endcase
  end

  assign in_ready      = !q_full;
  assign q_push        = in_valid && !q_full;
  assign q_cmd.kind    = kind;
  assign q_cmd.speed   = in_speed_kmh;
  assign q_cmd.time_ms = in_time_ms;

endmodule

FILE: rtl/spfo_queue.sv
// ----------------------------------------------------------------------------
// spfo_queue
// short command queue between the front and back parts
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spfo_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_r <= CNT_W'(DEPTH), "queue count overflow")

endmodule

FILE: rtl/spfo_div.sv
// ----------------------------------------------------------------------------
// spfo_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spfo_div (
  input  logic               clk,
  input  logic               rst_n,
  input  spfo_pkg::div_req_t req,
  output spfo_pkg::div_rsp_t rsp
);

  logic [spfo_pkg::NUM_W-1:0] quo_r, quo_nxt;
  logic [spfo_pkg::DEN_W-1:0] rem_r, rem_nxt;
  logic [spfo_pkg::DEN_W-1:0] den_r;
  logic [spfo_pkg::CNT_W-1:0] cnt_r;
  logic                       busy_r, done_r;
  logic [spfo_pkg::DEN_W:0]   trial, diff;
  logic                       ge;

  assign trial = {rem_r, quo_r[spfo_pkg::NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = (trial >= {1'b0, den_r});

  always_comb begin
    rem_nxt = ge ? diff[spfo_pkg::DEN_W-1:0] : trial[spfo_pkg::DEN_W-1:0];
    quo_nxt = {quo_r[spfo_pkg::NUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end else if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= spfo_pkg::CNT_W'(spfo_pkg::NUM_W - 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end else if (req.start) begin
      quo_r <= req.num;
      rem_r <= '0;
      den_r <= req.den;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

  `ASSERT_IMPLIES(a_done_idle, clk, rst_n, done_r, !busy_r, "divider done while busy")

endmodule

FILE: rtl/spfo_back.sv
// ----------------------------------------------------------------------------
// spfo_back
// executes queued commands, holds the pulse state and the result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spfo_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic [spfo_pkg::MODE_W-1:0]   cfg_hz_per_mph_mode,
  input  logic                          q_valid,
  input  spfo_pkg::cmd_t                q_cmd,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_pin_level,
  output logic [spfo_pkg::FREQ_W-1:0]   out_freq_hz
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_LOAD = 5'b00100,
    S_DIV  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t                       state_r, state_nxt;
  logic [spfo_pkg::MODE_W-1:0]  mode_r;
  logic [spfo_pkg::FREQ_W-1:0]  target_freq_r, target_freq_nxt;
  logic [spfo_pkg::HP_W-1:0]    half_period_r, half_period_nxt;
  logic [spfo_pkg::TIME_W-1:0]  last_toggle_r, last_toggle_nxt;
  logic                         pin_r, pin_nxt;
  logic [spfo_pkg::SM_W-1:0]    sm_r, sm_nxt;
  logic [spfo_pkg::FREQ_W-1:0]  f_r, f_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_pin_level_r, out_pin_level_nxt;
  logic [spfo_pkg::FREQ_W-1:0]  out_freq_hz_r, out_freq_hz_nxt;
  logic                         slot_free;
  logic [spfo_pkg::TIME_W-1:0]  elapsed;
  logic [spfo_pkg::PROD_W-1:0]  prod;
  logic [spfo_pkg::SM_W-1:0]    f_raw;
  logic [spfo_pkg::FREQ_W-1:0]  f_clamp;
  logic [spfo_pkg::HP_W-1:0]    hp_clamp;
  spfo_pkg::div_req_t           div_req;
  spfo_pkg::div_rsp_t           div_rsp;

  spfo_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign slot_free = !out_valid_r || out_ready;
  assign elapsed   = q_cmd.time_ms - last_toggle_r;

  // speed times mode times 1000 / 1609 by reciprocal multiplication
  assign prod  = spfo_pkg::PROD_W'(sm_r) * spfo_pkg::PROD_W'(spfo_pkg::FREQ_RECIP);
  assign f_raw = prod[spfo_pkg::RECIP_SHIFT +: spfo_pkg::SM_W];

  always_comb begin
    if (f_raw == '0) begin
      f_clamp = spfo_pkg::FREQ_MIN_HZ;
    end else if (f_raw > spfo_pkg::SM_W'(spfo_pkg::FREQ_MAX_HZ)) begin
      f_clamp = spfo_pkg::FREQ_MAX_HZ;
    end else begin
      f_clamp = f_raw[spfo_pkg::FREQ_W-1:0];
    end
    hp_clamp = (div_rsp.quo == '0) ? spfo_pkg::HP_MIN : div_rsp.quo[spfo_pkg::HP_W-1:0];
  end

  always_comb begin
    state_nxt         = state_r;
    target_freq_nxt   = target_freq_r;
    half_period_nxt   = half_period_r;
    last_toggle_nxt   = last_toggle_r;
    pin_nxt           = pin_r;
    sm_nxt            = sm_r;
    f_nxt             = f_r;
    out_valid_nxt     = out_valid_r && !out_ready;
    out_pin_level_nxt = out_pin_level_r;
    out_freq_hz_nxt   = out_freq_hz_r;
    q_pop             = 1'b0;
    div_req.start     = 1'b0;
    div_req.num       = spfo_pkg::HALF_PERIOD_NUM;
    div_req.den       = f_r;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          if (q_cmd.kind == spfo_pkg::K_SET) begin
            q_pop     = 1'b1;
            sm_nxt    = spfo_pkg::SM_W'(q_cmd.speed) * spfo_pkg::SM_W'(mode_r);
            state_nxt = S_MUL;
          end else if (slot_free) begin
            q_pop = 1'b1;
            case (q_cmd.kind)
              spfo_pkg::K_ZERO: begin
                target_freq_nxt = '0;
                half_period_nxt = '0;
                pin_nxt         = 1'b0;
              end
              spfo_pkg::K_TICK: begin
                if (target_freq_r != '0 &&
                    elapsed >= spfo_pkg::TIME_W'(half_period_r)) begin
                  pin_nxt         = !pin_r;
                  last_toggle_nxt = q_cmd.time_ms;
                end
              end
              spfo_pkg::K_STOP: begin
                target_freq_nxt = '0;
                half_period_nxt = '0;
                pin_nxt         = 1'b0;
                last_toggle_nxt = '0;
              end
              default: begin
              end
            endcase
            out_valid_nxt     = 1'b1;
            out_pin_level_nxt = pin_nxt;
            out_freq_hz_nxt   = target_freq_nxt;
          end
        end
      end
      S_MUL: begin
        f_nxt     = f_clamp;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        div_req.start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          target_freq_nxt = f_r;
          half_period_nxt = hp_clamp;
          state_nxt       = S_OUT;
        end
      end
      S_OUT: begin
        if (slot_free) begin
          out_valid_nxt     = 1'b1;
          out_pin_level_nxt = pin_r;
          out_freq_hz_nxt   = target_freq_r;
          state_nxt         = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      mode_r        <= spfo_pkg::MODE_RESET;
      target_freq_r <= '0;
      half_period_r <= '0;
      last_toggle_r <= '0;
      pin_r         <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      target_freq_r <= target_freq_nxt;
      half_period_r <= half_period_nxt;
      last_toggle_r <= last_toggle_nxt;
      pin_r         <= pin_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_valid) begin
        mode_r <= cfg_hz_per_mph_mode;
      end
    end
  end

  always_ff @(posedge clk) begin
    sm_r            <= sm_nxt;
    f_r             <= f_nxt;
    out_pin_level_r <= out_pin_level_nxt;
    out_freq_hz_r   <= out_freq_hz_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_pin_level = out_pin_level_r;
  assign out_freq_hz   = out_freq_hz_r;

  `ASSERT_ALWAYS(a_freq_hp_pair, clk, rst_n, (target_freq_r == '0) == (half_period_r == '0), "frequency and half period disagree")
  `ASSERT_IMPLIES(a_div_done_state, clk, rst_n, div_rsp.done, state_r == S_DIV, "divider result with no consumer")
  `ASSERT_IMPLIES(a_out_freq_max, clk, rst_n, out_valid_r, out_freq_hz_r <= spfo_pkg::FREQ_MAX_HZ, "result frequency out of range")

endmodule

FILE: rtl/speed_pulse_frequency_output_top.sv
// tick, stop, zero speed, ignored: queued then registered, one item per cycle while out_ready
// set speed: states S_MUL, S_LOAD, S_DIV (22-step 500/f), S_OUT; next item waits for the result
// items are accepted while the queue has room, also while a result waits to be taken
// rst_n is synchronous active low: FSM idle, pulse state zero, mode register returns to 1
// configuration writes are taken in every cycle
// ----------------------------------------------------------------------------
// speed_pulse_frequency_output_top
// speed pulse generator with a classifying front, command queue and executing back
// ----------------------------------------------------------------------------
module speed_pulse_frequency_output_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [spfo_pkg::MODE_W-1:0]   cfg_hz_per_mph_mode,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [spfo_pkg::OP_W-1:0]     in_op,
  input  logic [spfo_pkg::SPEED_W-1:0]  in_speed_kmh,
  input  logic [spfo_pkg::TIME_W-1:0]   in_time_ms,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_pin_level,
  output logic [spfo_pkg::FREQ_W-1:0]   out_freq_hz
);

  logic           q_full, q_push, q_pop, q_valid;
  spfo_pkg::cmd_t push_cmd, head_cmd;

  assign cfg_ready = 1'b1;

  spfo_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_op        (in_op),
    .in_speed_kmh (in_speed_kmh),
    .in_time_ms   (in_time_ms),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (push_cmd)
  );

  spfo_queue #(
    .WIDTH ($bits(spfo_pkg::cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (head_cmd)
  );

  spfo_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_hz_per_mph_mode (cfg_hz_per_mph_mode),
    .q_valid             (q_valid),
    .q_cmd               (head_cmd),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_pin_level       (out_pin_level),
    .out_freq_hz         (out_freq_hz)
  );

endmodule
